@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the heater regulator.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/hpr_pkg.sv @@
// Package of the heater regulator: widths, constants, codes and shared types.
// No dependencies; imported by every module of the block.
`default_nettype none

package hpr_pkg;

  // Field and register widths
  localparam int TEMP_W      = 12;
  localparam int CFG_W       = 11;
  localparam int REG_IDX_W   = 3;
  localparam int DRIVE_W     = 16;
  localparam int MODE_W      = 3;
  localparam int ERR_W       = 13;
  localparam int MAG_W       = 12;
  localparam int PID_ERR_W   = 9;
  localparam int INTEG_W     = 21;
  localparam int HIST_W      = 10;
  localparam int DERR_W      = 11;
  localparam int COUNT_W     = 8;
  localparam int STEP_W      = $clog2(COUNT_W);
  localparam int PPROD_W     = 20;
  localparam int IPROD_W     = 29;
  localparam int DPROD_W     = 21;
  localparam int SUM_W       = 23;
  localparam int ITERM_W     = 19;

  // Integral in milli-units
  localparam int            STEP_PROD_W = 15;
  localparam logic [STEP_PROD_W-1:0] INTEG_STEP = 15'd45;
  localparam logic [INTEG_W-1:0]     INTEG_MAX  = 21'd1500000;

  localparam logic [1:0]         ALARM_DEBOUNCE = 2'd2;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX      = 16'hFFFF;

  // Divide by 1000: shift by 3, then multiply by ceil(2^33/125) and shift by 33
  localparam int DIV_PRE_SHIFT = 3;
  localparam int DIV_Y_W       = IPROD_W - DIV_PRE_SHIFT;
  localparam int RECIP_W       = 27;
  localparam int RECIP_SHIFT   = 33;
  localparam int DIVP_W        = DIV_Y_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_125 = 27'd68719477;

  // Register reset values
  localparam logic [10:0] RST_TARGET = 11'd400;
  localparam logic [10:0] RST_ALARM  = 11'd300;
  localparam logic [7:0]  RST_KP     = 8'd30;
  localparam logic [7:0]  RST_KI     = 8'd1;
  localparam logic [9:0]  RST_KD     = 10'd500;
  localparam logic [6:0]  RST_BAND   = 7'd5;
  localparam logic [8:0]  RST_LIMIT  = 9'd60;
  localparam logic [7:0]  RST_PERIOD = 8'd20;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET       = 3'd0,
    REG_ALARM        = 3'd1,
    REG_KP           = 3'd2,
    REG_KI           = 3'd3,
    REG_KD           = 3'd4,
    REG_BAND         = 3'd5,
    REG_LIMIT        = 3'd6,
    REG_DERIV_PERIOD = 3'd7
  } hpr_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_BAND    = 3'd0,
    MODE_COOL    = 3'd1,
    MODE_PROP    = 3'd2,
    MODE_PID     = 3'd3,
    MODE_INHIBIT = 3'd4
  } hpr_mode_t;

  // Status of the derivative history phase tracker
  typedef struct packed {
    logic busy;  // remainder recompute in progress
    logic due;   // next PID item refreshes the error history
  } hpr_phase_status_t;

  function automatic logic [DRIVE_W-1:0] sat_drive(input logic signed [SUM_W-1:0] v);
    logic [DRIVE_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(SUM_W-DRIVE_W){1'b0}}, DRIVE_MAX})) begin
      r = DRIVE_MAX;
    end else begin
      r = v[DRIVE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/heater_pid_regulator_top.sv @@
// Top level of the heater regulator: config registers, control law, pipeline.
// Depends on hpr_pkg, hpr_phase, hpr_div1000 and assert_macros.svh.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------------
//   config   | cfg_write                   | cfg_index, cfg_data
//   sample   | sample_valid / sample_stall | temperature, alarm_eval,
//            |                             | clear_integral
//   result   | result_valid / result_stall | heater_drive, mode, alarm_active
//
// One item per cycle while result_stall and the phase recompute allow; items
// pass the input, product, quotient and result registers. The regulator state
// (integral, error history, alarm debounce, held sample) closes its loop in
// the one stage between the input register and the product register.
// Writing deriv_period starts a remainder recompute of the history
// phase; sample_stall is high during it.
// Reset is synchronous on rst. Bubbles collapse: a stalled result only holds
// the stages that are full behind it.
`default_nettype none
`include "assert_macros.svh"

module heater_pid_regulator_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // config write port
  input  logic                                 cfg_write,
  input  logic [hpr_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [hpr_pkg::CFG_W-1:0]            cfg_data,
  // sample channel
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [hpr_pkg::TEMP_W-1:0]    temperature,
  input  logic                                 alarm_eval,
  input  logic                                 clear_integral,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [hpr_pkg::DRIVE_W-1:0]          heater_drive,
  output logic [hpr_pkg::MODE_W-1:0]           mode,
  output logic                                 alarm_active
);
  import hpr_pkg::*;

  // ---------------- configuration registers ----------------
  logic [10:0] target_temp;
  logic [10:0] alarm_temp;
  logic [7:0]  kp;
  logic [7:0]  ki;
  logic [9:0]  kd;
  logic [6:0]  band_half_width;
  logic [8:0]  prop_only_limit;
  logic [7:0]  deriv_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp     <= RST_TARGET;
      alarm_temp      <= RST_ALARM;
      kp              <= RST_KP;
      ki              <= RST_KI;
      kd              <= RST_KD;
      band_half_width <= RST_BAND;
      prop_only_limit <= RST_LIMIT;
      deriv_period    <= RST_PERIOD;
    end else if (cfg_write) begin
      unique case (hpr_reg_t'(cfg_index))
        REG_TARGET:       target_temp     <= cfg_data[10:0];
        REG_ALARM:        alarm_temp      <= cfg_data[10:0];
        REG_KP:           kp              <= cfg_data[7:0];
        REG_KI:           ki              <= cfg_data[7:0];
        REG_KD:           kd              <= cfg_data[9:0];
        REG_BAND:         band_half_width <= cfg_data[6:0];
        REG_LIMIT:        prop_only_limit <= cfg_data[8:0];
        REG_DERIV_PERIOD: deriv_period    <= cfg_data[7:0];
        default:          ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic v0, v1, v2;
  logic adv0, adv1, adv2, adv3;
  logic accept, fire1;
  hpr_phase_status_t phase_status;

  // a stage loads when it is empty or the one after it moves
  assign adv3   = !result_valid || !result_stall;
  assign adv2   = !v2 || adv3;
  assign adv1   = !v1 || adv2;
  assign adv0   = !v0 || adv1;
  assign sample_stall = !adv0 || phase_status.busy;
  assign accept = sample_valid && !sample_stall;
  assign fire1  = v0 && adv1;   // item leaves the input register, state commits

  // ---------------- input register ----------------
  logic signed [TEMP_W-1:0] s0_temp;
  logic                     s0_eval;
  logic                     s0_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv0) begin
      v0 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_temp  <= temperature;
      s0_eval  <= alarm_eval;
      s0_clear <= clear_integral;
    end
  end

  // ---------------- regulator state ----------------
  logic [INTEG_W-1:0]       integral_sum;
  logic [HIST_W-1:0]        last_error;
  logic [HIST_W-1:0]        prev_error;
  logic [1:0]               alarm_count;
  logic                     alarm_flag;
  logic signed [TEMP_W-1:0] held_temp;

  // ---------------- control law ----------------
  logic                       over_alarm;
  logic [1:0]                 cnt_inc;
  logic [1:0]                 alarm_count_next;
  logic                       alarm_flag_next;
  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W-1:0]    err_neg;
  logic [MAG_W-1:0]           err_mag;
  logic [PID_ERR_W-1:0]       err_pid;
  logic                       in_band;
  logic                       prop_over;
  hpr_mode_t                  mode_c;
  logic [INTEG_W-1:0]         integ_base;
  logic [STEP_PROD_W-1:0]     integ_step;
  logic [INTEG_W:0]           integ_raw;
  logic [INTEG_W-1:0]         integ_pid;
  logic signed [DERR_W-1:0]   derr;
  logic [PPROD_W-1:0]         prod_p_c;
  logic [IPROD_W-1:0]         prod_i_c;
  logic signed [2*DERR_W-1:0] prod_d_c;

  // alarm is judged on the sample held from the previous item
  assign over_alarm = $signed({held_temp[TEMP_W-1], held_temp}) >
                      $signed({2'b00, alarm_temp});
  assign cnt_inc = over_alarm ? (alarm_count + 2'd1) : 2'd0;

  always_comb begin
    alarm_count_next = alarm_count;
    alarm_flag_next  = alarm_flag;
    if (s0_eval) begin
      if (cnt_inc > ALARM_DEBOUNCE) begin
        alarm_count_next = ALARM_DEBOUNCE;
        alarm_flag_next  = 1'b1;
      end else begin
        alarm_count_next = cnt_inc;
        alarm_flag_next  = 1'b0;
      end
    end
  end

  assign err     = $signed({2'b00, target_temp}) - $signed({s0_temp[TEMP_W-1], s0_temp});
  assign err_neg = -err;
  assign err_mag = err[ERR_W-1] ? err_neg[MAG_W-1:0] : err[MAG_W-1:0];
  // only reached in PID mode, where the error is at most prop_only_limit
  assign err_pid = err_mag[PID_ERR_W-1:0];

  assign in_band   = (err == '0) || (err_mag < {5'b0, band_half_width});
  assign prop_over = err_mag > {3'b0, prop_only_limit};

  always_comb begin
    if (in_band) begin
      mode_c = MODE_BAND;
    end else if (err[ERR_W-1]) begin
      mode_c = MODE_COOL;
    end else if (alarm_flag_next) begin
      mode_c = MODE_INHIBIT;
    end else if (prop_over) begin
      mode_c = MODE_PROP;
    end else begin
      mode_c = MODE_PID;
    end
  end

  assign integ_base = s0_clear ? '0 : integral_sum;
  assign integ_step = {{(STEP_PROD_W-PID_ERR_W){1'b0}}, err_pid} * INTEG_STEP;
  assign integ_raw  = {1'b0, integ_base} + {{(INTEG_W+1-STEP_PROD_W){1'b0}}, integ_step};
  assign integ_pid  = (integ_raw > {1'b0, INTEG_MAX}) ? INTEG_MAX : integ_raw[INTEG_W-1:0];

  // difference taken before the history refresh
  assign derr = $signed({1'b0, last_error}) - $signed({1'b0, prev_error});

  assign prod_p_c = {{(PPROD_W-8){1'b0}}, kp} * {{(PPROD_W-MAG_W){1'b0}}, err_mag};
  assign prod_i_c = {{(IPROD_W-8){1'b0}}, ki} * {{(IPROD_W-INTEG_W){1'b0}}, integ_pid};
  assign prod_d_c = $signed({{(2*DERR_W-10){1'b0}}, kd}) *
                    $signed({{DERR_W{derr[DERR_W-1]}}, derr});

  hpr_phase u_phase (
    .clk     (clk),
    .rst     (rst),
    .period  (deriv_period),
    .restart (cfg_write && (cfg_index == REG_DERIV_PERIOD)),
    .advance (fire1 && (mode_c == MODE_PID)),
    .status  (phase_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      last_error   <= '0;
      prev_error   <= '0;
      alarm_count  <= '0;
      alarm_flag   <= 1'b0;
      held_temp    <= '0;
    end else if (fire1) begin
      integral_sum <= (mode_c == MODE_PID) ? integ_pid : integ_base;
      alarm_count  <= alarm_count_next;
      alarm_flag   <= alarm_flag_next;
      held_temp    <= s0_temp;
      if ((mode_c == MODE_PID) && phase_status.due) begin
        prev_error <= last_error;
        last_error <= {{(HIST_W-PID_ERR_W){1'b0}}, err_pid};
      end
    end
  end

  // ---------------- product register ----------------
  hpr_mode_t                 s1_mode;
  logic [PPROD_W-1:0]        s1_prod_p;
  logic [IPROD_W-1:0]        s1_prod_i;
  logic signed [DPROD_W-1:0] s1_prod_d;
  logic                      s1_alarm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire1) begin
      s1_mode   <= mode_c;
      s1_prod_p <= prod_p_c;
      s1_prod_i <= prod_i_c;
      s1_prod_d <= prod_d_c[DPROD_W-1:0];
      s1_alarm  <= alarm_flag_next;
    end
  end

  // ---------------- quotient register ----------------
  hpr_mode_t                 s2_mode;
  logic [PPROD_W-1:0]        s2_prod_p;
  logic signed [DPROD_W-1:0] s2_prod_d;
  logic                      s2_alarm;
  logic [ITERM_W-1:0]        s2_iterm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_mode   <= s1_mode;
      s2_prod_p <= s1_prod_p;
      s2_prod_d <= s1_prod_d;
      s2_alarm  <= s1_alarm;
    end
  end

  hpr_div1000 u_div (
    .clk      (clk),
    .en       (adv2),
    .dividend (s1_prod_i),
    .quotient (s2_iterm)
  );

  // ---------------- result register ----------------
  logic signed [SUM_W-1:0] total;
  logic [DRIVE_W-1:0]      drive_c;

  assign total = $signed({{(SUM_W-PPROD_W){1'b0}}, s2_prod_p}) +
                 $signed({{(SUM_W-ITERM_W){1'b0}}, s2_iterm}) +
                 $signed({{(SUM_W-DPROD_W){s2_prod_d[DPROD_W-1]}}, s2_prod_d});

  always_comb begin
    case (s2_mode)
      MODE_PROP: drive_c = sat_drive($signed({{(SUM_W-PPROD_W){1'b0}}, s2_prod_p}));
      MODE_PID:  drive_c = sat_drive(total);
      default:   drive_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv3) begin
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      heater_drive <= drive_c;
      mode         <= s2_mode;
      alarm_active <= s2_alarm;
    end
  end

  // ---------------- assertions ----------------
  `ASSERT_IMPLY(a_integ_bound, clk, rst, 1'b1, integral_sum <= INTEG_MAX, "integral above clamp")
  `ASSERT_NEXT(a_recalc_blocks, clk, rst, cfg_write && (cfg_index == REG_DERIV_PERIOD), sample_stall, "sample taken during phase recompute")
  `ASSERT_IMPLY(a_off_modes, clk, rst, result_valid && ((mode == MODE_BAND) || (mode == MODE_COOL) || (mode == MODE_INHIBIT)), heater_drive == '0, "heater driven in an off mode")
  `ASSERT_IMPLY(a_inhibit_alarm, clk, rst, result_valid && (mode == MODE_INHIBIT), alarm_active, "inhibit without alarm")

endmodule

`default_nettype wire

@@ rtl/hpr_phase.sv @@
// History phase tracker: keeps the PID call count and its remainder modulo
// the derivative period. Depends on hpr_pkg.
`default_nettype none

module hpr_phase (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hpr_pkg::COUNT_W-1:0]   period,
  input  logic                          restart,
  input  logic                          advance,
  output hpr_pkg::hpr_phase_status_t    status
);
  import hpr_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] phase;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] rem_next;
  logic [COUNT_W-1:0] period_eff;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   phase_inc;
  logic [STEP_W-1:0]  step;
  logic               busy;

  // period of zero acts as one
  assign period_eff = (period == '0) ? COUNT_W'(1) : period;

  // restoring remainder, one count bit per cycle, MSB first
  assign trial    = {rem, count[step]};
  assign rem_next = (trial >= {1'b0, period_eff}) ?
                    COUNT_W'(trial - {1'b0, period_eff}) : trial[COUNT_W-1:0];

  assign phase_inc = {1'b0, phase} + (COUNT_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      phase <= '0;
      rem   <= '0;
      step  <= '0;
      busy  <= 1'b0;
    end else if (restart) begin
      busy <= 1'b1;
      step <= STEP_W'(COUNT_W - 1);
      rem  <= '0;
    end else if (busy) begin
      rem <= rem_next;
      if (step == '0) begin
        busy  <= 1'b0;
        phase <= rem_next;
      end else begin
        step <= step - STEP_W'(1);
      end
    end else if (advance) begin
      count <= count + COUNT_W'(1);
      // count wraps to zero, and zero is a multiple of any period
      if ((count == {COUNT_W{1'b1}}) || (phase_inc == {1'b0, period_eff})) begin
        phase <= '0;
      end else begin
        phase <= phase_inc[COUNT_W-1:0];
      end
    end
  end

  assign status.busy = busy;
  assign status.due  = (phase == '0);

endmodule

`default_nettype wire

@@ rtl/hpr_div1000.sv @@
// Registered divide by 1000 of the integral product, by reciprocal multiply.
// Depends on hpr_pkg.
`default_nettype none

module hpr_div1000 (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hpr_pkg::IPROD_W-1:0]   dividend,
  output logic [hpr_pkg::ITERM_W-1:0]   quotient
);
  import hpr_pkg::*;

  logic [DIV_Y_W-1:0] eighth;
  logic [DIVP_W-1:0]  prod;

  // floor(x/1000) = floor(floor(x/8)/125); exact for all x below 2^29
  assign eighth = dividend[IPROD_W-1:DIV_PRE_SHIFT];
  assign prod   = {{RECIP_W{1'b0}}, eighth} * {{DIV_Y_W{1'b0}}, RECIP_125};

  always_ff @(posedge clk) begin
    if (en) begin
      quotient <= prod[RECIP_SHIFT +: ITERM_W];
    end
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for heater_pid_regulator_top: drives temperature samples
// under random gaps and result stalls, predicts every result in a scoreboard.
// Depends on hpr_pkg and the RTL of the regulator.

// One predicted result item
typedef struct {
  logic [15:0]        drive;
  hpr_pkg::hpr_mode_t mode;
  logic               alarm;
} regulator_out_t;

// Scoreboard: bit-exact copy of the regulator state and registers, plus the
// queue of results still owed by the block.
class regulator_scoreboard;
  int unsigned target_temp, alarm_temp, kp, ki, kd, band, prop_limit, period;
  int unsigned integ_milli, last_err, prev_err, hist_count, alarm_count;
  bit          alarm_on;
  int          held_temp;
  regulator_out_t owed_q[$];
  int unsigned fail_count;

  function new();
    target_temp = hpr_pkg::RST_TARGET;
    alarm_temp  = hpr_pkg::RST_ALARM;
    kp          = hpr_pkg::RST_KP;
    ki          = hpr_pkg::RST_KI;
    kd          = hpr_pkg::RST_KD;
    band        = hpr_pkg::RST_BAND;
    prop_limit  = hpr_pkg::RST_LIMIT;
    period      = hpr_pkg::RST_PERIOD;
    integ_milli = 0;
    last_err    = 0;
    prev_err    = 0;
    hist_count  = 0;
    alarm_count = 0;
    alarm_on    = 1'b0;
    held_temp   = 0;
    fail_count  = 0;
  endfunction

  function void set_reg(hpr_pkg::hpr_reg_t idx, int unsigned value);
    case (idx)
      hpr_pkg::REG_TARGET:       target_temp = value & 'h7FF;
      hpr_pkg::REG_ALARM:        alarm_temp  = value & 'h7FF;
      hpr_pkg::REG_KP:           kp          = value & 'hFF;
      hpr_pkg::REG_KI:           ki          = value & 'hFF;
      hpr_pkg::REG_KD:           kd          = value & 'h3FF;
      hpr_pkg::REG_BAND:         band        = value & 'h7F;
      hpr_pkg::REG_LIMIT:        prop_limit  = value & 'h1FF;
      hpr_pkg::REG_DERIV_PERIOD: period      = value & 'hFF;
      default: ;
    endcase
  endfunction

  // Advance the regulator by one accepted sample and queue its result.
  function void note_sample(int temp, bit eval, bit clr);
    int             err, derr;
    int unsigned    per;
    longint         total;
    regulator_out_t r;
    total = 0;
    if (clr) integ_milli = 0;
    if (eval) begin
      if (held_temp > int'(alarm_temp)) alarm_count = (alarm_count + 1) & 'h3;
      else alarm_count = 0;
      if (alarm_count > hpr_pkg::ALARM_DEBOUNCE) begin
        alarm_count = hpr_pkg::ALARM_DEBOUNCE;
        alarm_on    = 1'b1;
      end else begin
        alarm_on = 1'b0;
      end
    end
    held_temp = temp;
    err = int'(target_temp) - temp;
    if (err == 0 || (err < int'(band) && -err < int'(band))) begin
      r.mode = hpr_pkg::MODE_BAND;
    end else if (err < 0) begin
      r.mode = hpr_pkg::MODE_COOL;
    end else if (alarm_on) begin
      r.mode = hpr_pkg::MODE_INHIBIT;
    end else if (err > int'(prop_limit)) begin
      r.mode = hpr_pkg::MODE_PROP;
      total  = longint'(kp) * err;
    end else begin
      r.mode = hpr_pkg::MODE_PID;
      per = (period == 0) ? 1 : period;
      integ_milli += err * int'(hpr_pkg::INTEG_STEP);
      if (integ_milli > hpr_pkg::INTEG_MAX) integ_milli = hpr_pkg::INTEG_MAX;
      derr = int'(last_err) - int'(prev_err);   // taken before the history moves
      if (hist_count % per == 0) begin
        prev_err = last_err;
        last_err = err & 'h3FF;
      end
      hist_count = (hist_count + 1) & 'hFF;
      // I term: milli-units back to units, truncated
      total = longint'(kp) * err + (longint'(ki) * longint'(integ_milli)) / 1000
              + longint'(kd) * derr;
    end
    if (total < 0) r.drive = '0;
    else if (total > longint'(hpr_pkg::DRIVE_MAX)) r.drive = hpr_pkg::DRIVE_MAX;
    else r.drive = total[15:0];
    r.alarm = alarm_on;
    owed_q.push_back(r);
  endfunction

  function void check_result(logic [15:0] drive, logic [2:0] mode, logic alarm);
    regulator_out_t want;
    if (owed_q.size() == 0) begin
      $error("result with none owed: heater_drive %0d mode %0d alarm_active %0b",
             drive, mode, alarm);
      fail_count++;
      return;
    end
    want = owed_q.pop_front();
    if (drive !== want.drive) begin
      $error("heater_drive: expected %0d, actual %0d", want.drive, drive);
      fail_count++;
    end
    if (mode !== want.mode) begin
      $error("mode: expected %0d, actual %0d", want.mode, mode);
      fail_count++;
    end
    if (alarm !== want.alarm) begin
      $error("alarm_active: expected %0b, actual %0b", want.alarm, alarm);
      fail_count++;
    end
  endfunction
endclass

module testbench;
  import hpr_pkg::*;

  // Run limit: ~1000 items, even under heavy stalls, plus
  // drains and the period recomputes, stays far below this.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // Pipeline is 4 deep; settle a little longer than that before writes/end
  localparam int          SETTLE_CYCLES = 8;
  localparam int          RANDOM_PHASES = 3;
  localparam int          SETS_PER_PHASE = 4;
  localparam int          ITEMS_PER_SET = 67;

  typedef enum {SET_RANDOM, SET_MAX, SET_MIN} setting_kind_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [TEMP_W-1:0]   temperature = '0;
  logic                       alarm_eval = 1'b0;
  logic                       clear_integral = 1'b0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [DRIVE_W-1:0]         heater_drive;
  logic [MODE_W-1:0]          mode;
  logic                       alarm_active;

  regulator_scoreboard sb = new();

  // Register values the bench will program next, indexed by register code
  int unsigned cfg_vals [8];
  // Idle rates in percent: sender gaps and receiver stalls
  int unsigned src_idle_pct  = 17;
  int unsigned sink_stall_pct = 58;
  int unsigned cycle_count = 0;

  heater_pid_regulator_top uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .temperature    (temperature),
    .alarm_eval     (alarm_eval),
    .clear_integral (clear_integral),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .heater_drive   (heater_drive),
    .mode           (mode),
    .alarm_active   (alarm_active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stall each cycle at the current rate
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Result monitor. Sampled at the edge, so DUT outputs and result_stall are
  // the values that decided this handshake.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(heater_drive, mode, alarm_active);
  end

  // Present one item, hold it until taken, then predict its result. Gaps are
  // decided before valid rises, so valid never reacts to stall.
  task automatic send_sample(input int temp, input bit eval, input bit clr);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid   <= 1'b1;
    temperature    <= temp[TEMP_W-1:0];
    alarm_eval     <= eval;
    clear_integral <= clr;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(temp, eval, clr);
  endtask

  // Stop sending and wait until every owed result is back, then let the
  // pipeline settle. The block is idle afterwards.
  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers from cfg_vals, one per cycle. Only called idle.
  task automatic program_regs();
    hpr_reg_t r;
    r = r.first();
    do begin
      cfg_write <= 1'b1;
      cfg_index <= r;
      cfg_data  <= cfg_vals[r][CFG_W-1:0];
      @(posedge clk);
      sb.set_reg(r, cfg_vals[r]);
      r = r.next();
    end while (r != r.first());
    cfg_write <= 1'b0;
  endtask

  function automatic void choose_settings(setting_kind_t kind);
    case (kind)
      SET_MAX: begin
        cfg_vals[REG_TARGET]       = 1250;
        cfg_vals[REG_ALARM]        = 1250;
        cfg_vals[REG_KP]           = 255;
        cfg_vals[REG_KI]           = 255;
        cfg_vals[REG_KD]           = 1023;
        cfg_vals[REG_BAND]         = 100;
        cfg_vals[REG_LIMIT]        = 500;
        cfg_vals[REG_DERIV_PERIOD] = 255;
      end
      SET_MIN: begin
        cfg_vals[REG_TARGET]       = 0;
        cfg_vals[REG_ALARM]        = 0;
        cfg_vals[REG_KP]           = 0;
        cfg_vals[REG_KI]           = 0;
        cfg_vals[REG_KD]           = 0;
        cfg_vals[REG_BAND]         = 1;
        cfg_vals[REG_LIMIT]        = 1;
        cfg_vals[REG_DERIV_PERIOD] = 1;
      end
      default: begin
        cfg_vals[REG_TARGET] = $urandom_range(1250);
        // alarm often just above target, so PID runs are not always inhibited
        if ($urandom_range(1)) cfg_vals[REG_ALARM] = $urandom_range(1250);
        else cfg_vals[REG_ALARM] = (cfg_vals[REG_TARGET] + $urandom_range(150) > 1250) ?
                                   1250 : cfg_vals[REG_TARGET] + $urandom_range(150);
        cfg_vals[REG_KP] = $urandom_range(255);
        cfg_vals[REG_KI] = $urandom_range(255);
        cfg_vals[REG_KD] = $urandom_range(1023);
        cfg_vals[REG_BAND] = ($urandom_range(3) == 0) ? $urandom_range(1, 100)
                                                      : $urandom_range(1, 12);
        cfg_vals[REG_LIMIT] = $urandom_range(1, 500);
        // short periods keep the error history moving
        cfg_vals[REG_DERIV_PERIOD] = ($urandom_range(3) == 0) ? $urandom_range(1, 255)
                                                              : $urandom_range(1, 6);
      end
    endcase
  endfunction

  // Random item. Most samples land around the setpoint so the band edges,
  // PID and the P-only threshold are hit; the rest spans the whole range,
  // the extremes, the alarm threshold, and runs that trip the alarm.
  task automatic send_random_item();
    int unsigned pick;
    int          tgt, lim, temp;
    pick = $urandom_range(99);
    tgt  = int'(cfg_vals[REG_TARGET]);
    lim  = int'(cfg_vals[REG_ALARM]);
    if (pick < 60) begin
      temp = tgt + int'(cfg_vals[REG_BAND]) + 4
             - int'($urandom_range(cfg_vals[REG_LIMIT] + cfg_vals[REG_BAND] + 8));
    end else if (pick < 85) begin
      temp = int'($urandom_range(1800)) - 550;
    end else if (pick < 95) begin
      case ($urandom_range(3))
        0:       temp = -550;
        1:       temp = 1250;
        2:       temp = lim;
        default: temp = lim + 1;
      endcase
    end else begin
      // three evaluated over-threshold samples feed the alarm debounce; a
      // sample below target then shows the inhibit once the flag latches
      repeat (3) send_sample((lim < 1250) ? int'($urandom_range(lim + 1, 1250)) : 1250,
                             1'b1, 1'b0);
      temp = tgt - int'($urandom_range(1, 30));
    end
    if (temp < -550) temp = -550;
    else if (temp > 1250) temp = 1250;
    send_sample(temp, 1'($urandom_range(1)), $urandom_range(99) < 5);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed: reset values written back explicitly --------------------
    cfg_vals[REG_TARGET]       = RST_TARGET;
    cfg_vals[REG_ALARM]        = RST_ALARM;
    cfg_vals[REG_KP]           = RST_KP;
    cfg_vals[REG_KI]           = RST_KI;
    cfg_vals[REG_KD]           = RST_KD;
    cfg_vals[REG_BAND]         = RST_BAND;
    cfg_vals[REG_LIMIT]        = RST_LIMIT;
    cfg_vals[REG_DERIV_PERIOD] = RST_PERIOD;
    program_regs();

    send_sample(400, 1'b0, 1'b0);    // zero error
    send_sample(404, 1'b0, 1'b0);    // inside band, negative side
    send_sample(396, 1'b1, 1'b0);    // inside band; alarm count starts
    send_sample(395, 1'b0, 1'b0);    // error equal to band width: PID
    send_sample(500, 1'b0, 1'b0);    // cooling
    send_sample(-550, 1'b0, 1'b0);   // coldest sample, P only
    send_sample(1250, 1'b0, 1'b0);   // hottest sample, cooling
    send_sample(340, 1'b0, 1'b0);    // error at P-only limit: still PID
    send_sample(339, 1'b0, 1'b0);    // one past limit: P only
    send_sample(350, 1'b0, 1'b1);    // integral cleared
    // alarm debounce: third exceedance in a row latches the flag
    send_sample(1250, 1'b1, 1'b0);
    send_sample(1250, 1'b1, 1'b0);
    send_sample(380, 1'b1, 1'b0);    // heating blocked
    send_sample(200, 1'b1, 1'b0);    // still over on held sample
    send_sample(370, 1'b1, 1'b0);    // held below threshold: alarm drops
    drain();

    // zero band width and zero derivative period
    cfg_vals[REG_BAND]         = 0;
    cfg_vals[REG_DERIV_PERIOD] = 0;
    program_regs();
    send_sample(400, 1'b0, 1'b0);
    send_sample(399, 1'b0, 1'b0);
    send_sample(401, 1'b0, 1'b0);
    send_sample(398, 1'b0, 1'b0);
    drain();

    // top gains: positive and negative saturation of the drive
    choose_settings(SET_MAX);
    cfg_vals[REG_BAND]         = 1;
    cfg_vals[REG_DERIV_PERIOD] = 1;
    program_regs();
    send_sample(-550, 1'b1, 1'b0);
    send_sample(1250, 1'b1, 1'b0);
    send_sample(750, 1'b0, 1'b0);
    send_sample(1249, 1'b0, 1'b0);   // large positive D term
    send_sample(1000, 1'b0, 1'b1);

    // ---- Random: three idling profiles, four settings each -----------------
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 17; sink_stall_pct = 58; end
        1:       begin src_idle_pct = 58; sink_stall_pct = 17; end
        default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      endcase
      for (int s = 0; s < SETS_PER_PHASE; s++) begin
        drain();
        if (ph == 0 && s == 0) choose_settings(SET_MAX);
        else if (ph == 1 && s == 0) choose_settings(SET_MIN);
        else choose_settings(SET_RANDOM);
        program_regs();
        for (int n = 0; n < ITEMS_PER_SET; n++) begin
          // mid-set hold-off: sender waits for the pipeline to empty
          if (s == 1 && n == ITEMS_PER_SET / 2) begin
            sample_valid <= 1'b0;
            while (sb.owed_q.size() != 0) @(posedge clk);
          end
          send_random_item();
        end
      end
    end

    drain();
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
